[sv/rgse_pkg.sv]
package rgse_pkg;

  localparam int KernelW    = 3;
  localparam int KernelTaps = KernelW * KernelW;
  localparam int CfgDataW   = 36;
  localparam int DimW       = 14;

  localparam logic [12:0] WidthReset  = 13'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [12:0] MaxRows     = 13'd4096;

  localparam logic [9:0] GreyRecip = 10'd683;
  localparam int         GreyShift = 11;
  localparam logic [7:0] EdgeMax   = 8'd255;

  localparam logic KindPixel = 1'b0;
  localparam logic KindDrain = 1'b1;

  typedef enum logic [1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegGxCoeffs    = 2'd2,
    RegGyCoeffs    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        frame_end;
  } edge_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        frame_end;
  } meta_t;

  typedef struct packed {
    logic x_first;
    logic x_last;
    logic y_first;
    logic y_last;
  } border_t;

endpackage

[sv/rgse_stream_if.sv]
interface rgse_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/rgb_to_grey_sobel_edge_core.sv]
// An accepted item passes through s1, s2, s3, s4, the square-root steps and the output
// register to leave as a result; results trail the pixels by one row plus one pixel.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The registered line memory read is forwarded when consecutive items hit one column.
// Reset (rst, synchronous): counters, window, valid bits and configuration registers return to
// defaults; the line memory is not cleared and needs no clearing pass.
module rgb_to_grey_sobel_edge_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  rgse_stream_if.sink                     pixels,
  rgse_stream_if.source                   edges,
  input  logic                            cfg_write,
  input  rgse_pkg::reg_index_t            cfg_index,
  input  logic [rgse_pkg::CfgDataW-1:0]   cfg_data
);
  import rgse_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SqSteps = 8;

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [CfgDataW-1:0] gx_coeffs;
  logic [CfgDataW-1:0] gy_coeffs;

  logic [AW-1:0] col;
  logic [12:0]   row;
  logic [AW-1:0] ex;
  logic [11:0]   ey;
  logic [7:0]    win [KernelTaps];

  logic [DimW-1:0] used_w;
  logic [12:0]     used_h;
  logic adv, accept, in_frame, take, emit, col_last, x_last, y_last, frame_last;
  logic [9:0] rgb_sum;

  logic            s1_valid;
  logic [AW-1:0]   s1_col;
  logic [9:0]      s1_sum;
  logic            s1_emit;
  meta_t           s1_meta;
  border_t         s1_border;
  logic            s1_fwd;
  logic [15:0]     s1_fwd_data;
  logic [15:0]     rd_data;
  logic [15:0]     line_mem [MAX_WIDTH];
  logic [15:0]     line_data;
  logic [19:0]     grey_prod;
  logic [7:0]      grey;
  logic [7:0]      win_shift [KernelTaps];

  logic            s2_valid;
  logic [7:0]      s2_win [KernelTaps];
  meta_t           s2_meta;
  border_t         s2_border;
  logic            tap_on [KernelTaps];
  logic signed [12:0] prod_x [KernelTaps];
  logic signed [12:0] prod_y [KernelTaps];
  logic signed [15:0] gx_acc, gy_acc;

  logic            s3_valid;
  logic [14:0]     s3_gx, s3_gy;
  meta_t           s3_meta;

  logic            s4_valid;
  logic [29:0]     s4_sqx, s4_sqy;
  meta_t           s4_meta;
  logic [29:0]     sum_sq;

  logic            sq_valid [SqSteps+1];
  logic [15:0]     sq_rad   [SqSteps+1];
  logic [9:0]      sq_rem   [SqSteps+1];
  logic [7:0]      sq_root  [SqSteps+1];
  logic            sq_sat   [SqSteps+1];
  meta_t           sq_meta  [SqSteps+1];
  logic [11:0]     sq_cur   [SqSteps];
  logic [11:0]     sq_trial [SqSteps];

  logic            out_valid;
  edge_t           out_data;

  always_comb begin
    if (frame_width == 13'd0) begin
      used_w = DimW'(1);
    end else if ({1'b0, frame_width} > DimW'(MAX_WIDTH)) begin
      used_w = DimW'(MAX_WIDTH);
    end else begin
      used_w = {1'b0, frame_width};
    end
    if (frame_height == 13'd0) begin
      used_h = 13'd1;
    end else if (frame_height > MaxRows) begin
      used_h = MaxRows;
    end else begin
      used_h = frame_height;
    end
  end

  assign adv        = !out_valid || edges.ready;
  assign accept     = pixels.valid && adv;
  assign in_frame   = row < used_h;
  assign take       = accept && !(in_frame && pixels.data.kind == KindDrain);
  assign emit       = (row > 13'd1) || (row == 13'd1 && col != '0);
  assign col_last   = (DimW'(col) + DimW'(1)) == used_w;
  assign x_last     = (DimW'(ex) + DimW'(1)) == used_w;
  assign y_last     = ({1'b0, ey} + 13'd1) == used_h;
  assign frame_last = x_last && y_last;
  assign rgb_sum    = in_frame ? (10'(pixels.data.red) + 10'(pixels.data.green)
                                  + 10'(pixels.data.blue)) : 10'd0;

  assign pixels.ready = adv;

  assign line_data = s1_fwd ? s1_fwd_data : rd_data;
  assign grey_prod = 20'(s1_sum) * 20'(GreyRecip);
  assign grey      = grey_prod[GreyShift+7:GreyShift];

  always_comb begin
    for (int j = 0; j < KernelW; j++) begin
      for (int i = 0; i < KernelW - 1; i++) begin
        win_shift[j*KernelW+i] = win[j*KernelW+i+1];
      end
    end
    win_shift[KernelW-1]             = line_data[15:8];
    win_shift[2*KernelW-1]           = line_data[7:0];
    win_shift[KernelTaps-1]          = grey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WidthReset;
      frame_height <= HeightReset;
      gx_coeffs    <= '0;
      gy_coeffs    <= '0;
      col          <= '0;
      row          <= '0;
      ex           <= '0;
      ey           <= '0;
      for (int t = 0; t < KernelTaps; t++) win[t] <= '0;
    end else begin
      if (take) begin
        if (col_last) begin
          col <= '0;
          row <= row + 13'd1;
        end else begin
          col <= col + AW'(1);
        end
        if (emit) begin
          if (frame_last) begin
            col <= '0;
            row <= '0;
            ex  <= '0;
            ey  <= '0;
          end else if (x_last) begin
            ex <= '0;
            ey <= ey + 12'd1;
          end else begin
            ex <= ex + AW'(1);
          end
        end
      end
      if (adv && s1_valid) begin
        for (int t = 0; t < KernelTaps; t++) begin
          win[t] <= (s1_emit && s1_meta.frame_end) ? 8'd0 : win_shift[t];
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          RegFrameWidth, RegFrameHeight: begin
            if (cfg_index == RegFrameWidth) begin
              frame_width <= cfg_data[12:0];
            end else begin
              frame_height <= cfg_data[12:0];
            end
            col <= '0;
            row <= '0;
            ex  <= '0;
            ey  <= '0;
            for (int t = 0; t < KernelTaps; t++) win[t] <= '0;
          end
          RegGxCoeffs: gx_coeffs <= cfg_data;
          RegGyCoeffs: gy_coeffs <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= line_mem[col];
    end
    if (adv && s1_valid) begin
      line_mem[s1_col] <= {line_data[7:0], grey};
    end
  end

  always_comb begin
    for (int j = 0; j < KernelW; j++) begin
      for (int i = 0; i < KernelW; i++) begin
        tap_on[j*KernelW+i] = !((i == 0 && s2_border.x_first) ||
                                (i == KernelW-1 && s2_border.x_last) ||
                                (j == 0 && s2_border.y_first) ||
                                (j == KernelW-1 && s2_border.y_last));
      end
    end
  end

  always_comb begin
    gx_acc = '0;
    gy_acc = '0;
    for (int t = 0; t < KernelTaps; t++) begin
      prod_x[t] = tap_on[t] ? signed'(gx_coeffs[4*t +: 4]) * signed'({1'b0, s2_win[t]})
                            : 13'sd0;
      prod_y[t] = tap_on[t] ? signed'(gy_coeffs[4*t +: 4]) * signed'({1'b0, s2_win[t]})
                            : 13'sd0;
      gx_acc = gx_acc + 16'(prod_x[t]);
      gy_acc = gy_acc + 16'(prod_y[t]);
    end
  end

  assign sum_sq = s4_sqx + s4_sqy;

  always_comb begin
    for (int k = 0; k < SqSteps; k++) begin
      sq_cur[k]   = {sq_rem[k], sq_rad[k][15:14]};
      sq_trial[k] = {2'b00, sq_root[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_fwd    <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= SqSteps; k++) sq_valid[k] <= 1'b0;
    end else if (adv) begin
      s1_valid  <= take;
      s1_fwd    <= s1_valid && (s1_col == col);
      s2_valid  <= s1_valid && s1_emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      sq_valid[0] <= s4_valid;
      for (int k = 0; k < SqSteps; k++) sq_valid[k+1] <= sq_valid[k];
      out_valid <= sq_valid[SqSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col            <= col;
      s1_sum            <= rgb_sum;
      s1_emit           <= emit;
      s1_meta.pixel_x   <= 12'(ex);
      s1_meta.pixel_y   <= ey;
      s1_meta.frame_end <= frame_last;
      s1_border         <= '{x_first: ex == '0, x_last: x_last,
                             y_first: ey == '0, y_last: y_last};
      s1_fwd_data       <= {line_data[7:0], grey};

      for (int t = 0; t < KernelTaps; t++) s2_win[t] <= win_shift[t];
      s2_meta   <= s1_meta;
      s2_border <= s1_border;

      s3_gx   <= gx_acc[15] ? 15'd0 : gx_acc[14:0];
      s3_gy   <= gy_acc[15] ? 15'd0 : gy_acc[14:0];
      s3_meta <= s2_meta;

      s4_sqx  <= 30'(s3_gx) * 30'(s3_gx);
      s4_sqy  <= 30'(s3_gy) * 30'(s3_gy);
      s4_meta <= s3_meta;

      sq_rad[0]  <= sum_sq[15:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_sat[0]  <= sum_sq[29:16] != '0;
      sq_meta[0] <= s4_meta;
      for (int k = 0; k < SqSteps; k++) begin
        sq_rad[k+1]  <= {sq_rad[k][13:0], 2'b00};
        sq_sat[k+1]  <= sq_sat[k];
        sq_meta[k+1] <= sq_meta[k];
        if (sq_cur[k] >= sq_trial[k]) begin
          sq_rem[k+1]  <= 10'(sq_cur[k] - sq_trial[k]);
          sq_root[k+1] <= {sq_root[k][6:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= sq_cur[k][9:0];
          sq_root[k+1] <= {sq_root[k][6:0], 1'b0};
        end
      end

      out_data.edge_value <= sq_sat[SqSteps] ? EdgeMax : sq_root[SqSteps];
      out_data.pixel_x    <= sq_meta[SqSteps].pixel_x;
      out_data.pixel_y    <= sq_meta[SqSteps].pixel_y;
      out_data.frame_end  <= sq_meta[SqSteps].frame_end;
    end
  end

  assign edges.valid = out_valid;
  assign edges.data  = out_data;

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    DimW'(col) < used_w)
    else $error("column count reached the frame width");

  a_result_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ey} < used_h)
    else $error("result row beyond the frame height");

  a_drain_rows: assert property (@(posedge clk) disable iff (rst)
    row <= used_h + 13'd2)
    else $error("row count ran past the drain phase");

endmodule

[bench/edge_checker.sv]
`timescale 1ns / 1ps
module edge_checker
  import rgse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rgse_stream_if                pixels,
  rgse_stream_if                edges,
  input  logic                  cfg_write,
  input  reg_index_t            cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data,
  output int                    fail_count,
  output int                    edges_owed
);

  localparam int LineDepth   = 4096;
  localparam int RowLimit    = 4096;
  localparam int GreyDivisor = 3;

  logic [7:0]  upper_line [LineDepth];
  logic [7:0]  middle_line [LineDepth];
  logic [7:0]  win [KernelTaps];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned emitted;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [35:0] gx_reg;
  logic [35:0] gy_reg;
  edge_t       expected_edges [$];
  int          fails = 0;

  function automatic int unsigned clamp_size(input logic [12:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
    foreach (win[k]) win[k] = '0;
  endfunction

  function automatic logic [7:0] root_clipped(input longint s);
    logic [7:0] r;
    logic [7:0] t;
    if (s >= 65536) return EdgeMax;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      t = r | 8'(1 << k);
      if (longint'(t) * longint'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic bit edge_for_pixel(input pixel_t px, output edge_t res);
    int unsigned w, h, c, m, x, y;
    logic [7:0]  grey, upper_px, middle_px;
    int          sx, sy, a, b, t;
    w = clamp_size(width_reg, LineDepth);
    h = clamp_size(height_reg, RowLimit);
    c = col_pos;
    grey = '0;
    sx = 0;
    sy = 0;
    res = '0;
    if (row_pos < h) begin
      if (px.kind == KindDrain) return 1'b0;
      grey = 8'((int'(px.red) + int'(px.green) + int'(px.blue)) / GreyDivisor);
    end
    m = row_pos * w + c;
    upper_px = upper_line[c];
    middle_px = middle_line[c];
    upper_line[c] = middle_px;
    middle_line[c] = grey;
    for (int j = 0; j < KernelW; j++) begin
      for (int i = 0; i < KernelW - 1; i++) win[j*KernelW + i] = win[j*KernelW + i + 1];
    end
    win[KernelW - 1] = upper_px;
    win[2*KernelW - 1] = middle_px;
    win[3*KernelW - 1] = grey;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (m < w + 1) return 1'b0;
    x = emitted % w;
    y = emitted / w;
    for (int j = 0; j < KernelW; j++) begin
      for (int i = 0; i < KernelW; i++) begin
        a = int'(x) + i - KernelW / 2;
        b = int'(y) + j - KernelW / 2;
        if (a >= 0 && b >= 0 && a < int'(w) && b < int'(h)) begin
          t = j * KernelW + i;
          sx += int'($signed(gx_reg[4*t +: 4])) * int'(win[t]);
          sy += int'($signed(gy_reg[4*t +: 4])) * int'(win[t]);
        end
      end
    end
    if (sx < 0) sx = 0;
    if (sy < 0) sy = 0;
    res.edge_value = root_clipped(longint'(sx) * sx + longint'(sy) * sy);
    res.pixel_x = 12'(x);
    res.pixel_y = 12'(y);
    if (emitted + 1 == w * h) begin
      res.frame_end = 1'b1;
      restart_frame();
    end else begin
      res.frame_end = 1'b0;
      emitted++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    edge_t got;
    edge_t want;
    if (rst) begin
      width_reg = WidthReset;
      height_reg = HeightReset;
      gx_reg = '0;
      gy_reg = '0;
      foreach (upper_line[k]) begin
        upper_line[k] = '0;
        middle_line[k] = '0;
      end
      restart_frame();
      expected_edges.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          RegFrameWidth: begin
            width_reg = cfg_data[12:0];
            restart_frame();
          end
          RegFrameHeight: begin
            height_reg = cfg_data[12:0];
            restart_frame();
          end
          RegGxCoeffs: gx_reg = cfg_data[35:0];
          RegGyCoeffs: gy_reg = cfg_data[35:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) begin
        if (edge_for_pixel(pixels.data, want)) expected_edges.push_back(want);
      end
      if (edges.valid && edges.ready) begin
        got = edges.data;
        if (expected_edges.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected edge item value %0d x %0d y %0d end %0b", $realtime,
                     got.edge_value, got.pixel_x, got.pixel_y, got.frame_end);
        end else begin
          want = expected_edges.pop_front();
          if (got.edge_value !== want.edge_value || got.pixel_x !== want.pixel_x ||
              got.pixel_y !== want.pixel_y || got.frame_end !== want.frame_end) begin
            fails++;
            if (fails <= 10)
              $display("%0t: edge mismatch, expected value %0d x %0d y %0d end %0b, got value %0d x %0d y %0d end %0b",
                       $realtime, want.edge_value, want.pixel_x, want.pixel_y, want.frame_end,
                       got.edge_value, got.pixel_x, got.pixel_y, got.frame_end);
          end
        end
      end
    end
    fail_count <= fails;
    edges_owed <= expected_edges.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import rgse_pkg::*;

  localparam logic [35:0] SobelX = 36'h10F20E10F;
  localparam logic [35:0] SobelY = 36'h121000FEF;
  localparam logic [35:0] AllMax = {9{4'h7}};
  localparam logic [35:0] AllMin = {9{4'h8}};
  localparam int          SettleCycles = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  reg_index_t          cfg_index = RegFrameWidth;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  fail_count;
  int                  edges_owed;

  rgse_stream_if #(.payload_t(pixel_t)) pixel_ch ();
  rgse_stream_if #(.payload_t(edge_t))  edge_ch ();

  rgb_to_grey_sobel_edge_core DUT (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixel_ch),
    .edges     (edge_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  edge_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixel_ch),
    .edges      (edge_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .edges_owed (edges_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    edge_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic pixel_t pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    return '{kind: KindPixel, red: r, green: g, blue: b};
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return pix(rand_channel(), rand_channel(), rand_channel());
  endfunction

  function automatic pixel_t drain_item();
    pixel_t p;
    p = rand_pixel();
    p.kind = KindDrain;
    return p;
  endfunction

  function automatic logic [35:0] rand_coeffs();
    case ($urandom_range(4))
      0: return SobelX;
      1: return SobelY;
      2: return AllMax;
      3: return AllMin;
      default: return {4'($urandom_range(15)), 32'($urandom)};
    endcase
  endfunction

  task automatic send(input pixel_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.data <= item;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  // hold the input until every owed edge item is out and the pipeline is empty
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (edges_owed != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input logic [35:0] gx,
                           input logic [35:0] gy);
    settle();
    write_reg(RegFrameWidth, CfgDataW'(w));
    write_reg(RegFrameHeight, CfgDataW'(h));
    write_reg(RegGxCoeffs, gx);
    write_reg(RegGyCoeffs, gy);
    cfg_write <= 1'b0;
  endtask

  task automatic run_frame(input int w, input int h, input bit abandon);
    int total;
    int cut;
    int swap_at;
    total = w * h;
    cut = abandon ? $urandom_range(total - 1) : -1;
    swap_at = ($urandom_range(5) == 0) ? $urandom_range(total - 1) : -1;
    for (int k = 0; k < total; k++) begin
      if (k == cut) return;
      if (k == swap_at) begin
        settle();
        write_reg(RegGxCoeffs, rand_coeffs());
        write_reg(RegGyCoeffs, rand_coeffs());
        cfg_write <= 1'b0;
      end
      if ($urandom_range(9) == 0) send(drain_item());
      send(rand_pixel());
    end
    // flush the tail; a pixel past the frame end acts as a drain
    for (int k = 0; k <= w; k++) send(($urandom_range(3) == 0) ? rand_pixel() : drain_item());
    if ($urandom_range(5) == 0) send(drain_item());
  endtask

  task automatic random_phase(input int budget);
    int  done_items;
    int  w;
    int  h;
    bit  reprogram;
    bit  abandon;
    done_items = 0;
    reprogram = 1'b1;
    w = 1;
    h = 1;
    while (done_items < budget) begin
      if (reprogram || $urandom_range(2) == 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        h = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        set_frame(w, h, rand_coeffs(), rand_coeffs());
      end
      abandon = ($urandom_range(7) == 0);
      run_frame(w, h, abandon);
      reprogram = abandon;
      done_items += w * h + w + 1;
    end
  endtask

  initial begin
    pixel_ch.valid = 1'b0;
    pixel_ch.data = '0;
    edge_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 84;

    // drain with nothing in flight
    send(drain_item());

    set_frame(3, 2, SobelX, SobelY);
    send(pix(8'hFF, 8'hFF, 8'hFF));
    send(pix(8'h00, 8'h00, 8'h00));
    send(pix(8'hFF, 8'h00, 8'h00));
    send(drain_item());
    send(pix(8'h00, 8'hFF, 8'h00));
    send(pix(8'h00, 8'h00, 8'hFF));
    send(pix(8'hFF, 8'hFF, 8'hFF));
    send(drain_item());
    send(pix(8'h12, 8'h34, 8'h56));
    send(drain_item());
    send(drain_item());

    // zero sizes act as one
    set_frame(0, 0, AllMax, AllMin);
    send(pix(8'hFF, 8'hFF, 8'hFF));
    send(drain_item());
    send(drain_item());

    // abandon a frame by a size write
    set_frame(4, 3, AllMin, AllMax);
    repeat (5) send(rand_pixel());

    // coefficient change in the middle of a frame
    set_frame(2, 2, SobelX, SobelY);
    repeat (3) send(rand_pixel());
    settle();
    write_reg(RegGxCoeffs, AllMin);
    cfg_write <= 1'b0;
    send(pix(8'hFF, 8'h80, 8'h01));
    repeat (3) send(drain_item());

    random_phase(110);
    send_idle_pct = 84;
    recv_idle_pct = 29;
    random_phase(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(100);

    // oversize writes clamp; each frame but the last is cut short by the next size write
    set_frame(8191, 1, rand_coeffs(), rand_coeffs());
    repeat (12) send(rand_pixel());
    set_frame(1, 8191, rand_coeffs(), rand_coeffs());
    repeat (12) send(rand_pixel());
    set_frame(4096, 0, SobelX, SobelY);
    repeat (12) send(rand_pixel());

    settle();
    if (fail_count == 0 && edges_owed == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

[sim.f]
sv/rgse_pkg.sv
sv/rgse_stream_if.sv
sv/rgb_to_grey_sobel_edge_core.sv
bench/edge_checker.sv
bench/testbench.sv
